FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled in reset.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/lmpi_pkg.sv
// ----------------------------------------------------------------------------
// lmpi_pkg
// Shared types and codes for the linear move planner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lmpi_pkg;
  // Number of axes; the port list carries one target and one value per axis.
  localparam int AXES = 4;

  localparam logic OP_PLAN   = 1'b0;
  localparam logic OP_INTERP = 1'b1;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

FILE: hw/rtl/lmpi_divider.sv
// ----------------------------------------------------------------------------
// lmpi_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lmpi_divider
  import lmpi_pkg::*;
#(
  parameter int NUM_W = 49,
  parameter int DEN_W = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output div_ctl_t         ctl,
  output logic [NUM_W-1:0] quo
);
  localparam int CW = $clog2(NUM_W + 1);
  logic [NUM_W-1:0] n;
  logic [DEN_W:0]   r;
  logic [DEN_W-1:0] d;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   rs;

  assign rs    = {r[DEN_W-1:0], n[NUM_W-1]};
  assign trial = rs - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
        n    <= num;
        d    <= den;
        r    <= '0;
      end else if (busy) begin
        if (!trial[DEN_W]) r <= trial;
        else r <= rs;
        n   <= {n[NUM_W-2:0], ~trial[DEN_W]};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = n;
  assign ctl = '{start: start, busy: busy, done: done};
endmodule

FILE: hw/rtl/linear_move_planner_interpolator.sv
// ----------------------------------------------------------------------------
// linear_move_planner_interpolator
// Plans multi-axis linear moves and interpolates positions along them.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake         | Word
// in      | input     | in_valid/in_ready | op, target_*, step_index
// out     | output    | out_valid/out_ready | kind, ignored, major_axis, ...
//
// A plan word registers its distances, scans the axes in turn to find the major
// axis, then runs one division per axis on the shared restoring divider, with a
// quotient of FRACTION_BITS+33 bits; a move of zero length is marked ignored instead.
// An interpolate word does one axis at a time, non-major axes on the shared multiplier.
// Reset is synchronous and clears all stored position, offset and slope state.
// in_ready is high only while the sequencer is idle and the output is empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module linear_move_planner_interpolator
  import lmpi_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic signed [31:0] target_0,
  input  logic signed [31:0] target_1,
  input  logic signed [31:0] target_2,
  input  logic signed [31:0] target_3,
  input  logic signed [31:0] step_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic        ignored,
  output logic [1:0]  major_axis,
  output logic signed [31:0] major_distance,
  output logic signed [31:0] value_0,
  output logic signed [31:0] value_1,
  output logic signed [31:0] value_2,
  output logic signed [31:0] value_3
);
  localparam int AW  = $clog2(AXES);
  localparam int SW  = FRACTION_BITS + 2;
  localparam int NW  = 33 + FRACTION_BITS;
  localparam int PW  = 32 + SW;
  localparam logic signed [SW-1:0] ONE = SW'(1) << FRACTION_BITS;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIST = 6'b000010,
    S_MAX  = 6'b000100,
    S_DIV  = 6'b001000,
    S_MUL  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state;
  logic signed [31:0] cur   [AXES];
  logic signed [31:0] offs  [AXES];
  logic signed [SW-1:0] slp [AXES];
  logic [AW-1:0] mjr;
  logic signed [31:0] tgt   [AXES];
  logic signed [32:0] delta [AXES];
  logic signed [31:0] res   [AXES];
  logic signed [31:0] idx;
  logic [AW-1:0] ax;
  logic [AW-1:0] best;
  logic [32:0]   bestabs;
  logic          kind_r, ign_r, dstart, pending;
  logic signed [31:0] mdist;
  logic [NW-1:0] quo;
  div_ctl_t      dctl;
  logic [32:0]   absd;
  logic signed [PW-1:0] prod;
  logic signed [33:0] pos;
  logic signed [31:0] pos_sat;
  logic signed [33:0] mpos;

  assign absd = delta[ax][32] ? 33'(-delta[ax]) : 33'(delta[ax]);

  lmpi_divider #(.NUM_W(NW), .DEN_W(33)) u_div (
    .clk(clk), .rst(rst), .start(dstart),
    .num({absd, FRACTION_BITS'(0)}), .den(bestabs), .ctl(dctl), .quo(quo)
  );

  // Interpolation: floor shift of the signed product is an arithmetic shift.
  assign prod = PW'(idx) * PW'(slp[ax]);
  assign pos  = 34'(offs[ax]) + 34'(prod >>> FRACTION_BITS);
  assign mpos = 34'(offs[ax]) + 34'(idx);

  function automatic logic signed [31:0] sat(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign pos_sat = (ax == mjr) ? sat(mpos) : sat(pos);

  assign tgt[0] = target_0;
  assign tgt[1] = target_1;
  assign tgt[2] = target_2;
  assign tgt[3] = target_3;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      mjr    <= '0;
      dstart <= 1'b0;
      pending <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        cur[i] <= '0; offs[i] <= '0; slp[i] <= '0;
      end
    end else begin
      dstart <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_r <= op;
            idx    <= step_index;
            ign_r  <= 1'b0;
            mdist  <= '0;
            ax     <= '0;
            if (op == OP_PLAN) state <= S_DIST;
            else state <= S_MUL;
            for (int i = 0; i < AXES; i++)
              delta[i] <= 33'(tgt[i]) - 33'(cur[i]);
          end
        end
        S_DIST: begin
          best <= '0; bestabs <= '0; ax <= '0;
          state <= S_MAX;
        end
        S_MAX: begin
          if (absd > bestabs) begin
            bestabs <= absd; best <= ax;
          end
          if (ax == AW'(AXES - 1)) begin
            ax <= '0;
            if (absd == '0 && bestabs == '0) begin
              ign_r <= 1'b1;
              for (int i = 0; i < AXES; i++) res[i] <= '0;
              state <= S_OUT;
            end else begin
              state <= S_DIV;
              pending <= 1'b0;
            end
          end else ax <= ax + 1'b1;
        end
        S_DIV: begin
          if (!pending && !dctl.busy) begin
            dstart <= 1'b1; pending <= 1'b1;
          end else if (dctl.done) begin
            pending <= 1'b0;
            if (ax == best) slp[ax] <= ONE;
            else if (delta[ax][32] != delta[best][32]) slp[ax] <= -SW'(quo);
            else slp[ax] <= SW'(quo);
            if (ax == best) res[ax] <= 32'(ONE);
            else if (delta[ax][32] != delta[best][32]) res[ax] <= 32'(-$signed(SW'(quo)));
            else res[ax] <= 32'($signed(SW'(quo)));
            offs[ax] <= cur[ax];
            cur[ax]  <= cur[ax] + 32'(delta[ax]);
            if (ax == AW'(AXES - 1)) begin
              mjr   <= best;
              mdist <= sat(34'(delta[best]));
              state <= S_OUT;
            end else ax <= ax + 1'b1;
          end
        end
        S_MUL: begin
          res[ax] <= pos_sat;
          if (ax == AW'(AXES - 1)) state <= S_OUT;
          else ax <= ax + 1'b1;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign kind           = kind_r;
  assign ignored        = ign_r;
  assign major_axis     = ign_r ? 2'd0 : (kind_r ? 2'(mjr) : 2'(best));
  assign major_distance = kind_r ? 32'sd0 : mdist;
  assign value_0        = res[0];
  assign value_1        = res[1];
  assign value_2        = res[2];
  assign value_3        = res[3];

  `ASSERT_IMPL(a_ready_idle, clk, rst, in_ready, !out_valid)
  `ASSERT_NEXT(a_done_div, clk, rst, dctl.done, state != S_DIV || dctl.busy == 1'b0)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
endmodule
